// ===== rtl/mvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mvt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_ROWS      = 4;
  localparam int unsigned NUM_COLS      = 4;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned NUM_REGS      = 8;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic [NUM_COLS-1:0][DATA_W-1:0] row_t;
  typedef logic [CFG_W-1:0]                mat_reg_t;

  localparam mat_reg_t MAT_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

`default_nettype wire

// ===== rtl/mvt_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_lane #(
  parameter int unsigned FracBits = mvt_pkg::FRAC_BITS_DEF,
  parameter int unsigned SumW     = mvt_pkg::PROD_W - FracBits + 2
) (
  input  wire                     clk_i,
  input  mvt_pkg::row_t           m_i,
  input  mvt_pkg::row_t           v_i,
  output logic signed [SumW-1:0]  sum_o
);

  localparam int unsigned ShW = mvt_pkg::PROD_W - FracBits;

  logic signed [mvt_pkg::PROD_W-1:0] prod_d [mvt_pkg::NUM_COLS];
  logic signed [mvt_pkg::PROD_W-1:0] prod_q [mvt_pkg::NUM_COLS];
  logic signed [mvt_pkg::PROD_W-1:0] shr    [mvt_pkg::NUM_COLS];
  logic signed [SumW-1:0]            ext    [mvt_pkg::NUM_COLS];
  logic signed [SumW-1:0]            sum_d;
  logic signed [SumW-1:0]            sum_q;

  for (genvar c = 0; c < mvt_pkg::NUM_COLS; c++) begin : g_col
    logic signed [mvt_pkg::DATA_W-1:0] a;
    logic signed [mvt_pkg::DATA_W-1:0] b;
    assign a         = $signed(m_i[c]);
    assign b         = $signed(v_i[c]);
    assign prod_d[c] = a * b;
    assign shr[c]    = prod_q[c] >>> FracBits;
    assign ext[c]    = $signed({{2{shr[c][ShW-1]}}, shr[c][ShW-1:0]});
  end

  assign sum_d = ext[0] + ext[1] + ext[2] + ext[3];

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

`default_nettype wire

// ===== rtl/mvt_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mvt_merge #(
  parameter int unsigned SumW = mvt_pkg::PROD_W - mvt_pkg::FRAC_BITS_DEF + 2
) (
  input  wire                              clk_i,
  input  wire [mvt_pkg::NUM_ROWS-1:0][SumW-1:0] sum_i,
  output mvt_pkg::row_t                    res_o,
  output logic                             ovf_o
);

  localparam int unsigned HiW = SumW - mvt_pkg::DATA_W + 1;

  mvt_pkg::row_t                res_d;
  mvt_pkg::row_t                res_q;
  logic [mvt_pkg::NUM_ROWS-1:0] sat;
  logic                         ovf_q;

  for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++) begin : g_row
    logic [HiW-1:0] hi;
    assign hi       = sum_i[r][SumW-1:mvt_pkg::DATA_W-1];
    assign sat[r]   = (hi != '0) && (hi != '1);
    assign res_d[r] = !sat[r]           ? sum_i[r][mvt_pkg::DATA_W-1:0] :
                      sum_i[r][SumW-1] ? mvt_pkg::SAT_MIN : mvt_pkg::SAT_MAX;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ovf_q <= |sat;
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/matrix_vector_transform_4x4.sv =====
// Channel   Handshake                     Payload
// input     start_i / busy_o              in_x_i, in_y_i, in_z_i, in_w_i
// result    valid_o (one-cycle strobe)    out_x_o, out_y_o, out_z_o, out_w_o, overflow_o
// config    cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// One vector per clock; busy_o stays low. The result is registered after the
// products of the sixteen 32x32 multipliers (four per row lane), the shifted
// row sums, then saturation and the overflow merge. Reset restores the identity
// matrix and clears the in-flight strobes. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none

module matrix_vector_transform_4x4 #(
  parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire signed [mvt_pkg::DATA_W-1:0] in_x_i,
  input  wire signed [mvt_pkg::DATA_W-1:0] in_y_i,
  input  wire signed [mvt_pkg::DATA_W-1:0] in_z_i,
  input  wire signed [mvt_pkg::DATA_W-1:0] in_w_i,
  output logic                             valid_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_x_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_y_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_z_o,
  output logic signed [mvt_pkg::DATA_W-1:0] out_w_o,
  output logic                             overflow_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire [mvt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [mvt_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned SumW = mvt_pkg::PROD_W - FRAC_BITS + 2;
  localparam int unsigned RegW = $clog2(mvt_pkg::NUM_REGS);

  mvt_pkg::mat_reg_t mat_q [mvt_pkg::NUM_REGS];
  mvt_pkg::row_t     vec;
  mvt_pkg::row_t     m_row [mvt_pkg::NUM_ROWS];
  logic [mvt_pkg::NUM_ROWS-1:0][SumW-1:0] sum;
  mvt_pkg::row_t     res;
  logic [2:0]        vld_q;
  logic              cfg_we;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i < mvt_pkg::CFG_IDX_W'(mvt_pkg::NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= mvt_pkg::MAT_RESET;
    end else if (cfg_we) begin
      mat_q[cfg_index_i[RegW-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i && !busy_o};
    end
  end

  assign vec = {in_w_i, in_z_i, in_y_i, in_x_i};

  for (genvar r = 0; r < mvt_pkg::NUM_ROWS; r++) begin : g_lane
    for (genvar c = 0; c < mvt_pkg::NUM_COLS; c++) begin : g_elem
      assign m_row[r][c] = mat_q[2*c + r/2][(r%2)*mvt_pkg::DATA_W +: mvt_pkg::DATA_W];
    end

    mvt_lane #(
      .FracBits (FRAC_BITS),
      .SumW     (SumW)
    ) u_lane (
      .clk_i (clk_i),
      .m_i   (m_row[r]),
      .v_i   (vec),
      .sum_o (sum[r])
    );
  end

  mvt_merge #(
    .SumW (SumW)
  ) u_merge (
    .clk_i (clk_i),
    .sum_i (sum),
    .res_o (res),
    .ovf_o (overflow_o)
  );

  assign valid_o = vld_q[2];
  assign out_x_o = $signed(res[0]);
  assign out_y_o = $signed(res[1]);
  assign out_z_o = $signed(res[2]);
  assign out_w_o = $signed(res[3]);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 valid_o)
    else $error("transfer did not produce a result after three cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 3))
    else $error("result strobe without an accepted transfer");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && overflow_o |->
      (out_x_o == mvt_pkg::SAT_MAX) || (out_x_o == mvt_pkg::SAT_MIN) ||
      (out_y_o == mvt_pkg::SAT_MAX) || (out_y_o == mvt_pkg::SAT_MIN) ||
      (out_z_o == mvt_pkg::SAT_MAX) || (out_z_o == mvt_pkg::SAT_MIN) ||
      (out_w_o == mvt_pkg::SAT_MAX) || (out_w_o == mvt_pkg::SAT_MIN))
    else $error("overflow flagged with no clamped row");

endmodule

`default_nettype wire

// ===== sim/tb_matrix_vector_transform_4x4.sv =====
`timescale 1ns / 1ps

module tb_matrix_vector_transform_4x4;
  import mvt_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int SMALL_SPAN = 1 << 18;
  localparam int ITEMS_EACH = 105;
  localparam int DRAIN_MAX  = 200;

  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

  localparam logic [DATA_W-1:0] CORNER_VALS [5] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF
  };

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
  } vec_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
    logic              ovf;
  } row_sums_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [DATA_W-1:0]    in_x_i      = '0;
  logic [DATA_W-1:0]    in_y_i      = '0;
  logic [DATA_W-1:0]    in_z_i      = '0;
  logic [DATA_W-1:0]    in_w_i      = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 busy_o;
  logic                 valid_o;
  logic [DATA_W-1:0]    out_x_o;
  logic [DATA_W-1:0]    out_y_o;
  logic [DATA_W-1:0]    out_z_o;
  logic [DATA_W-1:0]    out_w_o;
  logic                 overflow_o;
  logic                 cfg_ready_o;

  mat_reg_t matrix_copy [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  vec_t        pending_vecs [$];
  row_sums_t   expected_rows [$];
  vec_t        drv_item;
  row_sums_t   mon_want;
  int unsigned send_idle_pct = 21;
  int          mismatches    = 0;

  matrix_vector_transform_4x4 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_w_i      (in_w_i),
    .valid_o     (valid_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .overflow_o  (overflow_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic row_sums_t transform_vector(vec_t v);
    logic [DATA_W-1:0] comp [4];
    logic [DATA_W-1:0] lane [4];
    longint            acc;
    longint            prod;
    logic              ovf;
    row_sums_t         res;
    comp = '{v.x, v.y, v.z, v.w};
    ovf  = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) begin
        prod = longint'($signed(matrix_copy[2 * c + r / 2][DATA_W * (r % 2) +: DATA_W]))
               * longint'($signed(comp[c]));
        acc += prod >>> FRAC;
      end
      if (acc > Q_MAX) begin
        acc = Q_MAX;
        ovf = 1'b1;
      end else if (acc < Q_MIN) begin
        acc = Q_MIN;
        ovf = 1'b1;
      end
      lane[r] = acc[DATA_W-1:0];
    end
    res = '{lane[0], lane[1], lane[2], lane[3], ovf};
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] rand_q(int unsigned full_pct, int unsigned small_pct);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < full_pct) return $urandom;
    if (pick < full_pct + small_pct)
      return DATA_W'(int'($urandom_range(SMALL_SPAN)) - SMALL_SPAN / 2);
    return CORNER_VALS[$urandom_range(4)];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic write_matrix_reg(input logic [CFG_IDX_W-1:0] idx, input mat_reg_t data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_REGS) matrix_copy[idx] = data;
  endtask

  task automatic load_matrix(input bit random_fill, input logic [DATA_W-1:0] fill);
    for (int i = 0; i < NUM_REGS; i++) begin
      if (random_fill) write_matrix_reg(CFG_IDX_W'(i), {rand_q(20, 65), rand_q(20, 65)});
      else write_matrix_reg(CFG_IDX_W'(i), {fill, fill});
    end
  endtask

  task automatic push_vec(input logic [DATA_W-1:0] x, y, z, w);
    pending_vecs.push_back(vec_t'{x, y, z, w});
  endtask

  task automatic wait_drained();
    while (pending_vecs.size() != 0 || start_i) @(negedge clk_i);
    for (int n = 0; n < DRAIN_MAX && expected_rows.size() != 0; n++) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    while (expected_rows.size() != 0) begin
      report_mismatch("result never arrived");
      void'(expected_rows.pop_front());
    end
  endtask

  // hold the item until the transfer, then advance or drop start
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_rows.push_back(transform_vector(vec_t'{in_x_i, in_y_i, in_z_i, in_w_i}));
      end
      if (!(start_i && busy_o)) begin
        if (pending_vecs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = pending_vecs.pop_front();
          start_i <= 1'b1;
          in_x_i  <= drv_item.x;
          in_y_i  <= drv_item.y;
          in_z_i  <= drv_item.z;
          in_w_i  <= drv_item.w;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    logic [DATA_W-1:0] want [5];
    logic [DATA_W-1:0] seen [5];
    string             names [5];
    names = '{"out_x", "out_y", "out_z", "out_w", "overflow"};
    if (rst_ni && valid_o) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("result with no transfer outstanding");
      end else begin
        mon_want = expected_rows.pop_front();
        want = '{mon_want.x, mon_want.y, mon_want.z, mon_want.w, DATA_W'(mon_want.ovf)};
        seen = '{out_x_o, out_y_o, out_z_o, out_w_o, DATA_W'(overflow_o)};
        for (int i = 0; i < 5; i++) begin
          if (want[i] !== seen[i])
            report_mismatch($sformatf("%s expected %h got %h", names[i], want[i], seen[i]));
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_vec(32'h0, 32'h0, 32'h0, 32'h0);
    push_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
    push_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1);
    push_vec(32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000, 32'h8000_0000);
    wait_drained();

    load_matrix(1'b0, 32'h7FFF_FFFF);
    push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vec(32'h1, 32'h1, 32'h1, 32'h1);
    push_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
    wait_drained();

    load_matrix(1'b0, 32'h8000_0000);
    push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vec(32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
    wait_drained();

    // half-LSB products: negative ones must floor to minus one
    load_matrix(1'b0, 32'h0000_8000);
    push_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_vec(32'h1, 32'h1, 32'h1, 32'h1);
    push_vec(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1);
    wait_drained();

    for (int i = NUM_REGS; i < 2 ** CFG_IDX_W; i++)
      write_matrix_reg(CFG_IDX_W'(i), {$urandom, $urandom});
    push_vec(32'hFFFF_FFFF, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 49 : 0;
      for (int set = 0; set < 3; set++) begin
        load_matrix(1'b1, '0);
        repeat (ITEMS_EACH) push_vec(rand_q(45, 40), rand_q(45, 40), rand_q(45, 40),
                                     rand_q(45, 40));
        wait_drained();
      end
    end

    if (mismatches == 0) begin
      $display("matrix_vector_transform_4x4 test passed");
    end else begin
      $display("matrix_vector_transform_4x4 test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("matrix_vector_transform_4x4 test failed");
    $finish;
  end

endmodule
